@@ sv/ata_pkg.sv @@
package ata_pkg;

    // input masks carry one bit per thread for this many threads
    localparam int MASK_W = 16;
    localparam int TIDX_W = 4;

    localparam int DEF_TOTAL_THREADS    = 16;
    localparam int DEF_THREADS_PER_CORE = 4;

    // classification codes handed from front to back
    localparam logic [1:0] K_PREF = 2'd0;
    localparam logic [1:0] K_FREE = 2'd1;
    localparam logic [1:0] K_RR   = 2'd2;

    typedef struct packed {
        logic signed [2:0]   preferred_core;
        logic [MASK_W-1:0]   free_mask;
        logic [MASK_W-1:0]   blocked_mask;
    } t_req;

    typedef struct packed {
        logic                granted;
        logic [TIDX_W-1:0]   grant_thread;
        logic [1:0]          grant_core;
        logic                evicts_occupant;
    } t_rsp;

    typedef struct packed {
        logic [1:0]          kind;
        logic [TIDX_W-1:0]   thread;
        logic [MASK_W-1:0]   avail;
    } t_cls;

endpackage

@@ sv/ata_front.sv @@
module ata_front
    import ata_pkg::*;
#(
    parameter int TOTAL_THREADS    = DEF_TOTAL_THREADS,
    parameter int THREADS_PER_CORE = DEF_THREADS_PER_CORE
) (
    input  t_req i_req,
    output t_cls o_cls
);

    localparam int CORES = TOTAL_THREADS / THREADS_PER_CORE;

    logic [MASK_W-1:0] w_exist;
    logic [MASK_W-1:0] w_free;
    logic [MASK_W-1:0] w_pref;
    logic              w_pref_ok;

    function automatic logic [TIDX_W-1:0] lowest_set(input logic [MASK_W-1:0] m);
        logic [TIDX_W-1:0] idx;
        idx = '0;
        for (int k = MASK_W - 1; k >= 0; k--) begin
            if (m[k]) idx = TIDX_W'(k);
        end
        return idx;
    endfunction

    always_comb begin
        // negative or out-of-range preference means no preference
        w_pref_ok = !i_req.preferred_core[2] &&
                    (32'(i_req.preferred_core[1:0]) < CORES);
        for (int g = 0; g < MASK_W; g++) begin
            w_exist[g] = (g < TOTAL_THREADS);
        end
        w_free = i_req.free_mask & w_exist;
        for (int g = 0; g < MASK_W; g++) begin
            w_pref[g] = w_free[g] && w_pref_ok &&
                        ((g / THREADS_PER_CORE) == 32'(i_req.preferred_core[1:0]));
        end
    end

    always_comb begin
        o_cls.avail  = ~i_req.blocked_mask & w_exist;
        o_cls.thread = '0;
        if (|w_pref) begin
            o_cls.kind   = K_PREF;
            o_cls.thread = lowest_set(w_pref);
        end else if (|w_free) begin
            o_cls.kind   = K_FREE;
            o_cls.thread = lowest_set(w_free);
        end else begin
            o_cls.kind   = K_RR;
        end
    end

endmodule

@@ sv/ata_queue.sv @@
module ata_queue
    import ata_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cls o_data
);

    t_cls       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push ? !r_wptr : r_wptr;
        n_rptr  = i_pop  ? !r_rptr : r_rptr;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0)
        else $error("queue popped while empty");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop && !i_push |=> r_count == $past(r_count) - 2'd1)
        else $error("queue count did not drop on pop");

endmodule

@@ sv/ata_back.sv @@
module ata_back
    import ata_pkg::*;
#(
    parameter int TOTAL_THREADS    = DEF_TOTAL_THREADS,
    parameter int THREADS_PER_CORE = DEF_THREADS_PER_CORE
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_pop,
    input  t_cls i_cls,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int PW = $clog2(TOTAL_THREADS);

    logic [PW-1:0]            r_ptr, n_ptr;
    logic                     r_valid;
    t_rsp                     r_rsp, n_rsp;
    logic [PW-1:0]            w_start;
    logic [TOTAL_THREADS-1:0] w_cand;
    logic [TOTAL_THREADS-1:0] w_hi;
    logic [PW-1:0]            w_cand_idx;
    logic [PW-1:0]            w_hi_idx;
    logic [PW-1:0]            w_rr_idx;
    logic [TIDX_W-1:0]        w_thr;

    assign o_pop   = i_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // round robin starts one past the pointer, wrapping at the last thread
    assign w_start = (r_ptr == PW'(TOTAL_THREADS - 1)) ? '0 : r_ptr + 1'b1;

    always_comb begin
        w_cand_idx = '0;
        w_hi_idx   = '0;
        for (int i = 0; i < TOTAL_THREADS; i++) begin
            w_cand[i] = (i < MASK_W) ? i_cls.avail[i % MASK_W] : 1'b0;
            w_hi[i]   = w_cand[i] && (PW'(i) >= w_start);
        end
        for (int i = TOTAL_THREADS - 1; i >= 0; i--) begin
            if (w_cand[i]) w_cand_idx = PW'(i);
            if (w_hi[i])   w_hi_idx   = PW'(i);
        end
        w_rr_idx = (|w_hi) ? w_hi_idx : w_cand_idx;
    end

    always_comb begin
        n_ptr = r_ptr;
        w_thr = '0;
        n_rsp = '0;
        case (i_cls.kind)
            K_PREF: begin
                w_thr = i_cls.thread;
                n_rsp.granted = 1'b1;
            end
            K_FREE: begin
                w_thr = i_cls.thread;
                n_rsp.granted = 1'b1;
                n_ptr = PW'(i_cls.thread);
            end
            K_RR: begin
                if (|w_cand) begin
                    w_thr = TIDX_W'(w_rr_idx);
                    n_rsp.granted = 1'b1;
                    n_rsp.evicts_occupant = 1'b1;
                    n_ptr = w_rr_idx;
                end else begin
                    n_ptr = w_start;
                end
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
        if (n_rsp.granted) begin
            n_rsp.grant_thread = w_thr;
            // look up the core of each thread index as a constant
            for (int i = 0; i < MASK_W; i++) begin
                if (w_thr == TIDX_W'(i)) n_rsp.grant_core = 2'(i / THREADS_PER_CORE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) r_ptr <= n_ptr;
            if (o_pop) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_rsp <= n_rsp;
    end

    a_evict_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_rsp.evicts_occupant |-> r_rsp.granted)
        else $error("eviction without grant");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_rsp.granted |->
            r_rsp.grant_thread == '0 && r_rsp.grant_core == '0)
        else $error("failed request carries a thread");

    a_pref_keeps_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_cls.kind == K_PREF |=> $stable(r_ptr))
        else $error("preferred-core grant moved the pointer");

endmodule

@@ sv/affinity_thread_allocator.sv @@
// channel   | valid    | stall    | payload
// ----------+----------+----------+-----------------------------------
// request   | i_valid  | o_stall  | i_data (t_req: core, free, blocked)
// grant     | o_valid  | i_stall  | o_data (t_rsp: grant and eviction)
//
// One request per cycle sustained while o_stall is low; a taken request
// is classified into the queue, then its grant registered in the pointer stage.
// The round-robin pointer register in the back stage is the only loop.
// Reset is synchronous and clears the pointer, the queue and the output valid.
// A stalled grant holds; requests keep flowing until the two-entry queue fills.
module affinity_thread_allocator
    import ata_pkg::*;
#(
    parameter int TOTAL_THREADS    = DEF_TOTAL_THREADS,
    parameter int THREADS_PER_CORE = DEF_THREADS_PER_CORE
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_data
);

    t_cls w_cls_in;
    t_cls w_cls_out;
    logic w_full;
    logic w_q_valid;
    logic w_pop;

    assign o_stall = w_full;

    ata_front #(
        .TOTAL_THREADS   (TOTAL_THREADS),
        .THREADS_PER_CORE(THREADS_PER_CORE)
    ) u_front (
        .i_req(i_data),
        .o_cls(w_cls_in)
    );

    ata_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_valid && !w_full),
        .i_data (w_cls_in),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .i_pop  (w_pop),
        .o_data (w_cls_out)
    );

    ata_back #(
        .TOTAL_THREADS   (TOTAL_THREADS),
        .THREADS_PER_CORE(THREADS_PER_CORE)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_q_valid),
        .o_pop  (w_pop),
        .i_cls  (w_cls_out),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsp  (o_data)
    );

endmodule
